// ===== hdl/gfhp_pkg.sv =====
package gfhp_pkg;

  // Width of every field and register port
  localparam int DATA_W = 64;

  // Field polynomial after reset: x^64 + x^4 + x^3 + x + 1
  localparam logic [DATA_W-1:0] IRR_RESET = 64'd27;

endpackage

// ===== hdl/gfhp_red_table.sv =====
// Reduction rows x^(F+j) mod P for j = 0 .. F-2, rebuilt row by row
// after reset and after every write of the field polynomial.
module gfhp_red_table import gfhp_pkg::*; #(
  parameter int FIELD_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [DATA_W-1:0]                     cfg_data,
  output logic [FIELD_BITS-2:0][FIELD_BITS-1:0] rows,
  output logic                                  ready
);

  localparam int NROWS = FIELD_BITS - 1;
  localparam int IW    = $clog2(NROWS);

  logic [FIELD_BITS-1:0] poly;
  logic [FIELD_BITS-1:0] cur;
  logic [FIELD_BITS-1:0] cur_next;
  logic [IW-1:0]         idx;
  logic                  busy;

  // Multiply the current row by x and reduce
  always_comb begin
    cur_next = {cur[FIELD_BITS-2:0], 1'b0};
    if (cur[FIELD_BITS-1]) begin
      cur_next = cur_next ^ poly;
    end
  end

  // Build sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= IRR_RESET[FIELD_BITS-1:0];
      cur  <= IRR_RESET[FIELD_BITS-1:0];
      idx  <= '0;
      busy <= 1'b1;
    end else if (cfg_we) begin
      poly <= cfg_data[FIELD_BITS-1:0];
      cur  <= cfg_data[FIELD_BITS-1:0];
      idx  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      cur <= cur_next;
      idx <= idx + 1'b1;
      if (idx == IW'(NROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Row storage; no reset, every row is written before ready rises
  always_ff @(posedge clk) begin
    if (busy && !cfg_we) begin
      rows[idx] <= cur;
    end
  end

  assign ready = !busy;

endmodule

// ===== hdl/gfhp_horner_step.sv =====
// One Horner step: acc * point in GF(2^F), reduced through the row table,
// then xor with the coefficient. A leading coefficient restarts the sum.
module gfhp_horner_step import gfhp_pkg::*; #(
  parameter int FIELD_BITS = 64
) (
  input  logic [FIELD_BITS-1:0]                 acc,
  input  logic [FIELD_BITS-1:0]                 point,
  input  logic [FIELD_BITS-1:0]                 coeff,
  input  logic                                  first,
  input  logic [FIELD_BITS-2:0][FIELD_BITS-1:0] rows,
  output logic [FIELD_BITS-1:0]                 acc_next
);

  localparam int PW = 2 * FIELD_BITS - 1;

  logic [PW-1:0]         prod;
  logic [FIELD_BITS-1:0] red;

  // Carry-less product: xor of independent shifted partial products
  always_comb begin
    prod = '0;
    for (int k = 0; k < FIELD_BITS; k++) begin
      if (point[k]) begin
        prod = prod ^ (PW'(acc) << k);
      end
    end
  end

  // Fold the high half back with the precomputed rows
  always_comb begin
    red = prod[FIELD_BITS-1:0];
    for (int j = 0; j < FIELD_BITS - 1; j++) begin
      if (prod[FIELD_BITS+j]) begin
        red = red ^ rows[j];
      end
    end
  end

  assign acc_next = first ? coeff : (red ^ coeff);

endmodule

// ===== hdl/gf_horner_parity_bit_top.sv =====
// Horner evaluation of a polynomial over GF(2^FIELD_BITS), coefficients
// highest degree first; the transaction flagged first_coeff restarts the
// sum and latches eval_point and parity_mask, the one flagged last_coeff
// yields poly_value and extracted_bit (parity of value AND mask). One
// coefficient is taken per clock unless the table is rebuilding or a last
// coefficient waits for room in the result register: an input register
// feeds a combinational carry-less multiply and reduction into the
// accumulator, with the result held in an output register. The multiply
// reduces through a table of x^(F+j) mod P rows, rebuilt row by row
// after reset and each field_poly write; in_ready stays low until the
// table is rebuilt. Input bits at and above FIELD_BITS are ignored.
module gf_horner_parity_bit_top import gfhp_pkg::*; #(
  parameter int FIELD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] field_poly,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] coefficient,
  input  logic [DATA_W-1:0] eval_point,
  input  logic [DATA_W-1:0] parity_mask,
  input  logic              first_coeff,
  input  logic              last_coeff,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              extracted_bit,
  output logic [DATA_W-1:0] poly_value
);

  logic [FIELD_BITS-2:0][FIELD_BITS-1:0] rows;
  logic                  tbl_ready;

  // Input register
  logic                  s1_valid;
  logic [FIELD_BITS-1:0] s1_coeff;
  logic [FIELD_BITS-1:0] s1_point;
  logic [FIELD_BITS-1:0] s1_mask;
  logic                  s1_first;
  logic                  s1_last;
  logic                  s1_adv;

  // Evaluation state
  logic [FIELD_BITS-1:0] horner_acc;
  logic [FIELD_BITS-1:0] held_point;
  logic [FIELD_BITS-1:0] held_mask;
  logic [FIELD_BITS-1:0] acc_next;

  // Result register
  logic [FIELD_BITS-1:0] out_value;
  logic [FIELD_BITS-1:0] out_mask;
  logic                  out_free;

  assign cfg_ready = 1'b1;

  gfhp_red_table #(
    .FIELD_BITS (FIELD_BITS)
  ) u_red_table (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (field_poly),
    .rows     (rows),
    .ready    (tbl_ready)
  );

  gfhp_horner_step #(
    .FIELD_BITS (FIELD_BITS)
  ) u_horner_step (
    .acc      (horner_acc),
    .point    (held_point),
    .coeff    (s1_coeff),
    .first    (s1_first),
    .rows     (rows),
    .acc_next (acc_next)
  );

  // Handshake: only a last coefficient needs room in the result register
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_ready = tbl_ready && (!s1_valid || s1_adv);

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_coeff <= coefficient[FIELD_BITS-1:0];
      s1_point <= eval_point[FIELD_BITS-1:0];
      s1_mask  <= parity_mask[FIELD_BITS-1:0];
      s1_first <= first_coeff;
      s1_last  <= last_coeff;
    end
  end

  // Accumulator and sampled point and mask
  always_ff @(posedge clk) begin
    if (rst) begin
      horner_acc <= '0;
      held_point <= '0;
      held_mask  <= '0;
    end else if (s1_adv) begin
      horner_acc <= acc_next;
      if (s1_first) begin
        held_point <= s1_point;
        held_mask  <= s1_mask;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; mask travels along so a new evaluation can start
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_value <= acc_next;
      out_mask  <= s1_first ? s1_mask : held_mask;
    end
  end

  assign poly_value    = DATA_W'(out_value);
  assign extracted_bit = ^(out_value & out_mask);

endmodule

// ===== bench/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import gfhp_pkg::*;

  localparam int FIELD_W = 64;
  localparam int LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [DATA_W-1:0] FIELD_MASK = {DATA_W{1'b1}} >> (DATA_W - FIELD_W);
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  typedef struct packed {
    logic              bit_out;
    logic [DATA_W-1:0] value;
  } horner_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DATA_W-1:0] field_poly;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] coefficient;
  logic [DATA_W-1:0] eval_point;
  logic [DATA_W-1:0] parity_mask;
  logic              first_coeff;
  logic              last_coeff;
  logic              out_valid;
  logic              out_ready;
  logic              extracted_bit;
  logic [DATA_W-1:0] poly_value;

  // Shadow of the block's state for prediction
  logic [DATA_W-1:0] shadow_poly;
  logic [DATA_W-1:0] shadow_acc;
  logic [DATA_W-1:0] shadow_point;
  logic [DATA_W-1:0] shadow_mask;
  horner_result_t    pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int coeffs_taken;
  int results_checked;
  int poly_writes;
  int quiet_cycles;

  gf_horner_parity_bit_top #(.FIELD_BITS(FIELD_W)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .field_poly    (field_poly),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .coefficient   (coefficient),
    .eval_point    (eval_point),
    .parity_mask   (parity_mask),
    .first_coeff   (first_coeff),
    .last_coeff    (last_coeff),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .extracted_bit (extracted_bit),
    .poly_value    (poly_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Carry-less shift-and-add multiply, reduced by the field polynomial
  function automatic logic [DATA_W-1:0] field_mul(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] poly);
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] red;
    int k;
    prod = '0;
    red  = poly & FIELD_MASK;
    a    = a & FIELD_MASK;
    b    = b & FIELD_MASK;
    for (k = 0; k < FIELD_W; k++) begin
      if (b[0]) prod = prod ^ a;
      b = b >> 1;
      if (a[FIELD_W-1]) a = ((a << 1) & FIELD_MASK) ^ red;
      else a = (a << 1) & FIELD_MASK;
    end
    return prod & FIELD_MASK;
  endfunction

  // Mostly full-width random words, with the corner values mixed in
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return ALL_ONES;
      2: begin
        case ($urandom_range(4))
          0: return 64'h1;
          1: return 64'h3;
          2: return 64'hF;
          3: return 64'hFF;
          default: return 64'hFFFF;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: ready changes on the falling edge only
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on each accepted coefficient, check each accepted result
  always @(posedge clk) begin
    horner_result_t exp_res;
    horner_result_t got_res;
    logic [DATA_W-1:0] c;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        shadow_poly = field_poly;
        poly_writes++;
      end
      if (out_valid && out_ready) begin
        got_res.bit_out = extracted_bit;
        got_res.value   = poly_value;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: bit %0h value %0h",
                   $time, extracted_bit, poly_value);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (got_res.value !== exp_res.value) begin
            $display("%0t: poly_value expected %0h actual %0h",
                     $time, exp_res.value, got_res.value);
            error_count++;
          end
          if (got_res.bit_out !== exp_res.bit_out) begin
            $display("%0t: extracted_bit expected %0h actual %0h",
                     $time, exp_res.bit_out, got_res.bit_out);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        coeffs_taken++;
        c = coefficient & FIELD_MASK;
        if (first_coeff) begin
          shadow_point = eval_point & FIELD_MASK;
          shadow_mask  = parity_mask & FIELD_MASK;
          shadow_acc   = c;
        end else begin
          shadow_acc = field_mul(shadow_acc, shadow_point, shadow_poly) ^ c;
        end
        if (last_coeff) begin
          exp_res.bit_out = ^(shadow_acc & shadow_mask);
          exp_res.value   = shadow_acc & FIELD_MASK;
          pending_results.push_back(exp_res);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, pending_results.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // One coefficient transaction; valid is left high after acceptance
  task automatic send_coeff(input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] p,
                            input logic [DATA_W-1:0] m, input logic f, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    coefficient <= c;
    eval_point  <= p;
    parity_mask <= m;
    first_coeff <= f;
    last_coeff  <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Field polynomial is only rewritten once the block has gone quiet
  task automatic write_field_poly(input logic [DATA_W-1:0] value);
    release_input();
    wait_results();
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    field_poly <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed evaluations with random content, plus some loose transactions
  task automatic run_evaluations(input int n_items);
    int sent;
    int len;
    int k;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] m;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_coeff(pick_word(), pick_word(), pick_word(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        p = pick_word();
        m = pick_word();
        for (k = 0; k < len; k++) begin
          send_coeff(pick_word(), (k == 0) ? p : pick_word(), (k == 0) ? m : pick_word(),
                     (k == 0), (k == len - 1));
        end
        sent += len;
      end
      // hold off now and then until the output side has caught up
      if ($urandom_range(39) == 0) begin
        release_input();
        wait_results();
      end
    end
  endtask

  // Coefficients before any leading one run on the zero state
  task automatic test_before_first();
    send_coeff(64'h1, ALL_ONES, ALL_ONES, 1'b0, 1'b1);
    send_coeff(64'hFFFF, 64'h3, ALL_ONES, 1'b0, 1'b0);
    send_coeff(64'hF, 64'h0, 64'hFF, 1'b0, 1'b1);
  endtask

  // Leading and constant term in one transaction
  task automatic test_single_term();
    send_coeff(64'h0, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
    send_coeff(ALL_ONES, 64'h0, ALL_ONES, 1'b1, 1'b1);
    send_coeff(64'h3, 64'h1, 64'h0, 1'b1, 1'b1);
    send_coeff(64'hFF, ALL_ONES, 64'h1, 1'b1, 1'b1);
  endtask

  // Points of zero, one, all ones and the top bit alone
  task automatic test_horner_edges();
    send_coeff(ALL_ONES, 64'h1, 64'hFFFF, 1'b1, 1'b0);
    send_coeff(64'hFFFF, ALL_ONES, 64'h0, 1'b0, 1'b0);
    send_coeff(64'h3, 64'h0, 64'h0, 1'b0, 1'b1);
    send_coeff(64'hFF, 64'h0, ALL_ONES, 1'b1, 1'b0);
    send_coeff(64'hF, 64'h1, 64'h0, 1'b0, 1'b1);
    send_coeff(ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b0);
    send_coeff(ALL_ONES, 64'h0, 64'h0, 1'b0, 1'b0);
    send_coeff(ALL_ONES, 64'h0, 64'h0, 1'b0, 1'b1);
    send_coeff(64'h1, 64'h8000_0000_0000_0000, ALL_ONES, 1'b1, 1'b0);
    send_coeff(64'h0, 64'h0, 64'h0, 1'b0, 1'b0);
    send_coeff(64'h0, 64'h0, 64'h0, 1'b0, 1'b1);
    // abandoned evaluation, restarted by a fresh leading coefficient
    send_coeff(64'hFFFF, 64'h3, 64'hF, 1'b1, 1'b0);
    send_coeff(64'h1, 64'h3, 64'hF, 1'b1, 1'b0);
    send_coeff(64'hF, 64'h0, 64'h0, 1'b0, 1'b1);
  endtask

  // Several field polynomials, extremes included
  task automatic test_field_polys();
    logic [DATA_W-1:0] polys[5];
    int i;
    polys[0] = '0;
    polys[1] = ALL_ONES;
    polys[2] = {$urandom, $urandom};
    polys[3] = 64'h8000_0000_0000_001B;
    polys[4] = IRR_RESET;
    for (i = 0; i < 5; i++) begin
      write_field_poly(polys[i]);
      run_evaluations(60);
    end
  endtask

  // Random evaluations under each backpressure pattern
  task automatic test_flow_control();
    int i;
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 49, 0, 15};
    recv_pcts = '{0, 0, 49, 15};
    for (i = 0; i < 4; i++) begin
      send_idle_pct  = send_pcts[i];
      recv_stall_pct = recv_pcts[i];
      run_evaluations(390);
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    field_poly     = '0;
    in_valid       = 1'b0;
    coefficient    = '0;
    eval_point     = '0;
    parity_mask    = '0;
    first_coeff    = 1'b0;
    last_coeff     = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    coeffs_taken   = 0;
    results_checked = 0;
    poly_writes    = 0;
    quiet_cycles   = 0;
    shadow_poly    = IRR_RESET;
    shadow_acc     = '0;
    shadow_point   = '0;
    shadow_mask    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_first();
    test_single_term();
    test_horner_edges();
    test_field_polys();
    test_flow_control();

    release_input();
    wait_results();
    repeat (LATENCY + 6) @(posedge clk);

    $display("testbench: %0d coefficients taken, %0d results checked",
             coeffs_taken, results_checked);
    $display("testbench: %0d field polynomial writes, four backpressure patterns",
             poly_writes);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
